// ===== src/dhm_pkg.sv =====
// ----------------------------------------------------------------------------
// dhm_pkg
// Shared constants, command codes and controller/datapath interface types
// for the highest-takes-precedence DMX merge engine.
// ----------------------------------------------------------------------------
package dhm_pkg;

    // Store geometry.
    localparam int UNIVERSES = 4;
    localparam int SLOTS     = 512;
    localparam int DEPTH     = UNIVERSES * SLOTS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UNI_W     = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // At most four universes are reported on a commit.
    localparam int REPORT_MAX = 4;
    localparam int REPORT_N   = (UNIVERSES < REPORT_MAX) ? UNIVERSES : REPORT_MAX;

    // Full DMX output value.
    localparam logic [7:0] DMX_FULL = 8'hFF;

    // Divider: one overflow step plus eight quotient bits.
    localparam int DIV_STEPS = 9;
    localparam int STEP_W    = 4;

    // Operation codes carried in the cmd field.
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_CONTRIB = 2'd1,
        CMD_COMMIT  = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // latch the input word
        logic cnt_clr;       // reset the sweep counters
        logic cnt_step;      // advance the sweep counters by one entry
        logic rpt_step;      // advance the report universe
        logic init_wr;       // zero both stores at the sweep address
        logic clr_wr;        // zero the frame store at the sweep address
        logic mul_load;      // load products into the divider
        logic div_step;      // one restoring divider step
        logic frame_rd;      // read the frame store at the item address
        logic sweep_rd;      // read both stores at the sweep address
        logic chg_clr;       // clear the per-universe changed flags
        logic contrib_done;  // write back the frame entry and load the result
        logic read_rd;       // read the output store at the item address
        logic read_done;     // load the read result
        logic report_load;   // load one commit report
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;    // sweep counters point at the final entry
        logic rpt_last;      // report universe is the final one reported
        logic div_last;      // divider is on its final step
        logic out_free;      // result register can take a new word
    } dp_stat_t;

    // Linear store address of a universe and slot.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] uni,
                                                  input logic [ADDR_W-1:0] slot);
        logic [ADDR_W-1:0] base;
        base = uni * ADDR_W'(SLOTS);
        return base + slot;
    endfunction

endpackage

// ===== src/dhm_datapath.sv =====
// ----------------------------------------------------------------------------
// dhm_datapath
// Input capture, scaling multipliers, restoring divider, frame and output
// stores, sweep counters, changed flags and the result register.
// ----------------------------------------------------------------------------
module dhm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dhm_pkg::dp_cmd_t    ctl,
    output dhm_pkg::dp_stat_t   stat,
    input  logic [1:0]          universe,
    input  logic [8:0]          slot_number,
    input  logic [15:0]         level_a,
    input  logic [15:0]         level_b,
    input  logic [15:0]         full_value,
    input  logic [7:0]          own_num,
    input  logic [7:0]          own_den,
    input  logic                has_global,
    input  logic [7:0]          global_num,
    input  logic [7:0]          global_den,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          dmx_level,
    output logic [1:0]          universe_index,
    output logic                changed,
    output logic                last
);
    import dhm_pkg::*;

    // Captured input word.
    logic [1:0]  uni_q_reg;
    logic [8:0]  slot_q_reg;
    logic [15:0] level_a_reg;
    logic [15:0] level_b_reg;
    logic [15:0] full_reg;
    logic [7:0]  own_num_reg;
    logic [7:0]  own_den_reg;
    logic        has_global_reg;
    logic [7:0]  global_num_reg;
    logic [7:0]  global_den_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            uni_q_reg      <= universe;
            slot_q_reg     <= slot_number;
            level_a_reg    <= level_a;
            level_b_reg    <= level_b;
            full_reg       <= full_value;
            own_num_reg    <= own_num;
            own_den_reg    <= own_den;
            has_global_reg <= has_global;
            global_num_reg <= global_num;
            global_den_reg <= global_den;
        end
    end

    // Item address and its range check.
    logic [ADDR_W-1:0] item_addr;
    logic              item_ok;

    assign item_addr = addr_of(ADDR_W'(uni_q_reg), ADDR_W'(slot_q_reg));
    assign item_ok   = (32'(uni_q_reg) < 32'(UNIVERSES)) && (32'(slot_q_reg) < 32'(SLOTS));

    // Sweep counters: slot within universe, then universe.
    logic [UNI_W-1:0]  uni_cnt_reg;
    logic [SLOT_W-1:0] slot_cnt_reg;
    logic              slot_last;
    logic              uni_last;
    logic [ADDR_W-1:0] sweep_addr;

    assign slot_last  = (slot_cnt_reg == SLOT_W'(SLOTS - 1));
    assign uni_last   = (uni_cnt_reg == UNI_W'(UNIVERSES - 1));
    assign sweep_addr = addr_of(ADDR_W'(uni_cnt_reg), ADDR_W'(slot_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uni_cnt_reg  <= '0;
            slot_cnt_reg <= '0;
        end
        else if (ctl.cnt_clr)
        begin
            uni_cnt_reg  <= '0;
            slot_cnt_reg <= '0;
        end
        else if (ctl.cnt_step)
        begin
            if (slot_last)
            begin
                slot_cnt_reg <= '0;
                uni_cnt_reg  <= uni_cnt_reg + 1'b1;
            end
            else
            begin
                slot_cnt_reg <= slot_cnt_reg + 1'b1;
            end
        end
        else if (ctl.rpt_step)
        begin
            uni_cnt_reg <= uni_cnt_reg + 1'b1;
        end
    end

    // Scaling products: level*255*num over full*den.
    logic [15:0] lvl_max;
    logic        use_own;
    logic [7:0]  sel_num;
    logic [7:0]  sel_den;
    logic [23:0] lvl_x255;
    logic [31:0] numer;
    logic [23:0] denom;

    assign lvl_max  = (level_a_reg > level_b_reg) ? level_a_reg : level_b_reg;
    assign use_own  = (own_num_reg > 8'd1) || (own_den_reg > 8'd1) || !has_global_reg;
    assign sel_num  = use_own ? own_num_reg : global_num_reg;
    assign sel_den  = use_own ? own_den_reg : global_den_reg;
    assign lvl_x255 = {lvl_max, 8'd0} - {8'd0, lvl_max};
    assign numer    = 32'(lvl_x255) * 32'(sel_num);
    assign denom    = 24'(full_reg) * 24'(sel_den);

    // Restoring divider, one quotient bit per cycle from bit 8 down.
    // Bit 8 set means the quotient is at least 256 and is clamped.
    logic [31:0]          rem_reg;
    logic [23:0]          den_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [31:0]          div_sub;
    logic                 div_ge;
    logic [7:0]           scaled;

    assign div_sub = {8'd0, den_reg} << step_reg;
    assign div_ge  = (rem_reg >= div_sub);
    assign scaled  = q_reg[DIV_STEPS-1] ? DMX_FULL : q_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (ctl.mul_load)
        begin
            rem_reg  <= numer;
            den_reg  <= denom;
            q_reg    <= '0;
            step_reg <= STEP_W'(DIV_STEPS - 1);
        end
        else if (ctl.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - div_sub;
            end
            q_reg[step_reg] <= div_ge;
            step_reg        <= step_reg - 1'b1;
        end
    end

    // Frame and output stores with registered read data.
    logic [7:0] frame_mem [DEPTH];
    logic [7:0] output_mem [DEPTH];
    logic [7:0] frame_q_reg;
    logic [7:0] output_q_reg;

    // Commit pipeline stage: compare and copy one entry behind the read.
    logic              p1_valid_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [UNI_W-1:0]  p1_uni_reg;
    logic              raise;

    assign raise = item_ok && (scaled > frame_q_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.init_wr || ctl.clr_wr)
        begin
            frame_mem[sweep_addr] <= 8'd0;
        end
        else if (ctl.contrib_done && raise)
        begin
            frame_mem[item_addr] <= scaled;
        end
        if (ctl.frame_rd)
        begin
            frame_q_reg <= frame_mem[item_addr];
        end
        else if (ctl.sweep_rd)
        begin
            frame_q_reg <= frame_mem[sweep_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init_wr)
        begin
            output_mem[sweep_addr] <= 8'd0;
        end
        else if (p1_valid_reg)
        begin
            output_mem[p1_addr_reg] <= frame_q_reg;
        end
        if (ctl.read_rd)
        begin
            output_q_reg <= output_mem[item_addr];
        end
        else if (ctl.sweep_rd)
        begin
            output_q_reg <= output_mem[sweep_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_addr_reg <= sweep_addr;
        p1_uni_reg  <= uni_cnt_reg;
    end

    // Changed flags, one per universe.
    logic [UNIVERSES-1:0] chg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            chg_reg      <= '0;
        end
        else
        begin
            p1_valid_reg <= ctl.sweep_rd;
            if (ctl.chg_clr)
            begin
                chg_reg <= '0;
            end
            else if (p1_valid_reg && (frame_q_reg != output_q_reg))
            begin
                chg_reg[p1_uni_reg] <= 1'b1;
            end
        end
    end

    // Result register: holds one word until the receiver takes it.
    logic       out_valid_reg;
    logic [7:0] level_reg;
    logic [1:0] uidx_reg;
    logic       chg_out_reg;
    logic       last_reg;
    logic       rpt_last;

    assign rpt_last = (uni_cnt_reg == UNI_W'(REPORT_N - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.contrib_done || ctl.read_done || ctl.report_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.contrib_done)
        begin
            level_reg   <= scaled;
            uidx_reg    <= uni_q_reg;
            chg_out_reg <= 1'b0;
            last_reg    <= 1'b1;
        end
        else if (ctl.read_done)
        begin
            level_reg   <= item_ok ? output_q_reg : 8'd0;
            uidx_reg    <= uni_q_reg;
            chg_out_reg <= 1'b0;
            last_reg    <= 1'b1;
        end
        else if (ctl.report_load)
        begin
            level_reg   <= 8'd0;
            uidx_reg    <= 2'(uni_cnt_reg);
            chg_out_reg <= chg_reg[uni_cnt_reg];
            last_reg    <= rpt_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dmx_level      = level_reg;
    assign universe_index = uidx_reg;
    assign changed        = chg_out_reg;
    assign last           = last_reg;

    // Status back to the controller.
    assign stat.sweep_last = slot_last && uni_last;
    assign stat.rpt_last   = rpt_last;
    assign stat.div_last   = (step_reg == '0);
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

// ===== src/dhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhm_ctrl
// Sequencer for the merge engine: store clearing after reset, clear sweeps,
// contribute scaling and write-back, reads, and commit sweeps with reports.
// ----------------------------------------------------------------------------
module dhm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    output dhm_pkg::dp_cmd_t    ctl,
    input  dhm_pkg::dp_stat_t   stat
);
    import dhm_pkg::*;

    typedef enum logic [10:0] {
        S_INIT       = 11'b000_0000_0001,
        S_IDLE       = 11'b000_0000_0010,
        S_CLEAR      = 11'b000_0000_0100,
        S_MUL        = 11'b000_0000_1000,
        S_DIV        = 11'b000_0001_0000,
        S_CONTRIB    = 11'b000_0010_0000,
        S_READ_ISSUE = 11'b000_0100_0000,
        S_READ_OUT   = 11'b000_1000_0000,
        S_COMMIT     = 11'b001_0000_0000,
        S_DRAIN      = 11'b010_0000_0000,
        S_REPORT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new word is taken only in the idle state.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.init_wr  = 1'b1;
                ctl.cnt_step = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    unique case (cmd_t'(cmd))
                        CMD_CLEAR:   state_next = S_CLEAR;
                        CMD_CONTRIB: state_next = S_MUL;
                        CMD_COMMIT:
                        begin
                            ctl.chg_clr = 1'b1;
                            state_next  = S_COMMIT;
                        end
                        CMD_READ:    state_next = S_READ_ISSUE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                ctl.clr_wr   = 1'b1;
                ctl.cnt_step = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MUL:
            begin
                ctl.mul_load = 1'b1;
                ctl.frame_rd = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_CONTRIB;
                end
            end
            S_CONTRIB:
            begin
                if (stat.out_free)
                begin
                    ctl.contrib_done = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_READ_ISSUE:
            begin
                ctl.read_rd = 1'b1;
                state_next  = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.read_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_COMMIT:
            begin
                ctl.sweep_rd = 1'b1;
                ctl.cnt_step = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    ctl.report_load = 1'b1;
                    ctl.rpt_step    = 1'b1;
                    if (stat.rpt_last)
                    begin
                        ctl.cnt_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dmx_htp_merge_engine.sv =====
// ----------------------------------------------------------------------------
// dmx_htp_merge_engine
// Highest-takes-precedence DMX merge with frame and output stores.
// ----------------------------------------------------------------------------
// After reset the engine zeroes both 2048-entry stores, one entry per cycle,
// and holds in_stall high while it does so. Each input word is then
// handled alone. A contribute goes through capture, the multiply, nine steps
// of the restoring divider (overflow bit plus eight quotient bits) and the
// frame write-back with the result. A read goes through the registered output
// store port. A clear sweeps the frame store and gives no word. A commit walks
// both stores through a one-entry compare-and-copy pipeline and then gives one
// report word per universe, up to four, one per cycle unless out_stall holds
// them back. The result register lets the next input word be taken while a
// result is still waiting on out_stall.
// ----------------------------------------------------------------------------
module dmx_htp_merge_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [1:0]  universe,
    input  logic [8:0]  slot_number,
    input  logic [15:0] level_a,
    input  logic [15:0] level_b,
    input  logic [15:0] full_value,
    input  logic [7:0]  own_num,
    input  logic [7:0]  own_den,
    input  logic        has_global,
    input  logic [7:0]  global_num,
    input  logic [7:0]  global_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  dmx_level,
    output logic [1:0]  universe_index,
    output logic        changed,
    output logic        last
);
    import dhm_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequencer.
    dhm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .ctl      (ctl),
        .stat     (stat)
    );

    // Arithmetic, stores and result register.
    dhm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .universe       (universe),
        .slot_number    (slot_number),
        .level_a        (level_a),
        .level_b        (level_b),
        .full_value     (full_value),
        .own_num        (own_num),
        .own_den        (own_den),
        .has_global     (has_global),
        .global_num     (global_num),
        .global_den     (global_den),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dmx_level      (dmx_level),
        .universe_index (universe_index),
        .changed        (changed),
        .last           (last)
    );

endmodule

// ===== dv/tb_dmx_htp_merge_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dmx_htp_merge_engine
// Self-checking bench for the highest-takes-precedence DMX merge engine.
// A queue of input words is filled up front: a short directed set covering
// the scaler choice, zero divisors, clamping and the HTP rule, then random
// frames (clear, contributions, commit, reads) mixed with stray words. A
// shadow copy of both stores predicts every result word, and the monitor
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dmx_htp_merge_engine;

    import dhm_pkg::*;

    localparam int CYCLE_LIMIT    = 6000000;
    localparam int RANDOM_WORDS   = 480;
    localparam int DRAIN_EVERY    = 150;
    localparam int HOLDOFF_AT     = 80;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int END_SETTLE     = 2200;

    // One input word as offered to the engine.
    typedef struct {
        cmd_t        cmd;
        logic [1:0]  universe;
        logic [8:0]  slot_number;
        logic [15:0] level_a;
        logic [15:0] level_b;
        logic [15:0] full_value;
        logic [7:0]  own_num;
        logic [7:0]  own_den;
        logic        has_global;
        logic [7:0]  global_num;
        logic [7:0]  global_den;
        bit          drain_first;   // hold this word until every result is back
    } dmx_word_t;

    // One predicted result word.
    typedef struct {
        logic [7:0] dmx_level;
        logic [1:0] universe_index;
        logic       changed;
        logic       last;
    } merge_result_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd         = '0;
    logic [1:0]  universe    = '0;
    logic [8:0]  slot_number = '0;
    logic [15:0] level_a     = '0;
    logic [15:0] level_b     = '0;
    logic [15:0] full_value  = '0;
    logic [7:0]  own_num     = '0;
    logic [7:0]  own_den     = '0;
    logic        has_global  = 1'b0;
    logic [7:0]  global_num  = '0;
    logic [7:0]  global_den  = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  dmx_level;
    logic [1:0]  universe_index;
    logic        changed;
    logic        last;

    dmx_word_t     pending_words[$];
    merge_result_t merge_results[$];
    logic [7:0]    frame_shadow  [DEPTH] = '{default: 8'd0};
    logic [7:0]    output_shadow [DEPTH] = '{default: 8'd0};
    logic [8:0]    slot_pool     [8];

    int cycle_count   = 0;
    int error_count   = 0;
    int queued_count  = 0;
    int words_offered = 0;
    int words_taken   = 0;
    int results_taken = 0;
    int results_seen  = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int holdoff_left  = 0;
    bit holdoff_fired = 1'b0;

    dmx_htp_merge_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .universe       (universe),
        .slot_number    (slot_number),
        .level_a        (level_a),
        .level_b        (level_b),
        .full_value     (full_value),
        .own_num        (own_num),
        .own_den        (own_den),
        .has_global     (has_global),
        .global_num     (global_num),
        .global_den     (global_den),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dmx_level      (dmx_level),
        .universe_index (universe_index),
        .changed        (changed),
        .last           (last)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("mismatch (cycle %0d): %s", cycle_count, what);
        error_count++;
    endtask

    // Idle cycles before the next word; every fourth stretch of 40 runs flat out.
    function automatic int draw_pause(input int count);
        if ((count / 40) % 4 == 3)
            return 0;
        return ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 14)) : 0;
    endfunction

    function automatic dmx_word_t contrib_word(input logic [1:0] uni, input logic [8:0] slot,
                                               input logic [15:0] la, lb, full,
                                               input logic [7:0] own_n, own_d,
                                               input logic hg,
                                               input logic [7:0] glob_n, glob_d);
        dmx_word_t w;
        w.cmd         = CMD_CONTRIB;
        w.universe    = uni;
        w.slot_number = slot;
        w.level_a     = la;
        w.level_b     = lb;
        w.full_value  = full;
        w.own_num     = own_n;
        w.own_den     = own_d;
        w.has_global  = hg;
        w.global_num  = glob_n;
        w.global_den  = glob_d;
        w.drain_first = 1'b0;
        return w;
    endfunction

    // A non-contribute word; the fields it ignores carry random content.
    function automatic dmx_word_t op_word(input cmd_t c, input logic [1:0] uni,
                                          input logic [8:0] slot);
        dmx_word_t w;
        w = contrib_word(uni, slot, 16'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), 8'($urandom));
        w.cmd = c;
        return w;
    endfunction

    // Random contribution: mostly levels up to full scale, sometimes anything.
    function automatic dmx_word_t random_contrib(input logic [1:0] uni, input logic [8:0] slot);
        logic [15:0] full;
        logic [15:0] la;
        logic [15:0] lb;
        logic [7:0]  own_n;
        logic [7:0]  own_d;
        logic [7:0]  glob_d;
        full = ($urandom_range(0, 31) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 7) == 0)
        begin
            la = 16'($urandom);
            lb = 16'($urandom);
        end
        else
        begin
            la = 16'($urandom_range(0, full));
            lb = 16'($urandom_range(0, full));
        end
        // Own scaler of 0 or 1 on both parts lets the global scaler take over.
        if ($urandom_range(0, 2) == 0)
        begin
            own_n = 8'($urandom_range(0, 1));
            own_d = 8'($urandom_range(0, 1));
        end
        else
        begin
            own_n = 8'($urandom);
            own_d = 8'($urandom);
        end
        glob_d = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        return contrib_word(uni, slot, la, lb, full, own_n, own_d, 1'($urandom),
                            8'($urandom), glob_d);
    endfunction

    // Slots are drawn mostly from a small pool so that HTP merges and reads hit.
    function automatic logic [8:0] pick_slot();
        if ($urandom_range(0, 3) != 0)
            return slot_pool[$urandom_range(0, 7)];
        return 9'($urandom);
    endfunction

    function automatic void queue_word(input dmx_word_t w);
        if (queued_count % DRAIN_EVERY == DRAIN_EVERY - 1)
            w.drain_first = 1'b1;
        pending_words.push_back(w);
        queued_count++;
    endfunction

    // Merge predictor: updates the shadow stores and queues the result words.
    function automatic void apply_word(input dmx_word_t w);
        merge_result_t   r;
        longint unsigned lvl;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        logic [7:0]      v;
        int              idx;
        case (w.cmd)
            CMD_CLEAR:
            begin
                foreach (frame_shadow[i])
                    frame_shadow[i] = 8'd0;
            end
            CMD_CONTRIB:
            begin
                lvl = (w.level_a > w.level_b) ? w.level_a : w.level_b;
                if (w.own_num > 1 || w.own_den > 1 || !w.has_global)
                begin
                    num = w.own_num;
                    den = w.own_den;
                end
                else
                begin
                    num = w.global_num;
                    den = w.global_den;
                end
                den = den * w.full_value;
                // A zero divisor saturates, as the restoring divider returns all ones.
                if (den == 0)
                    v = DMX_FULL;
                else
                begin
                    q = (lvl * DMX_FULL * num) / den;
                    v = (q > DMX_FULL) ? DMX_FULL : 8'(q);
                end
                if (w.universe < UNIVERSES && w.slot_number < SLOTS)
                begin
                    idx = int'(w.universe) * SLOTS + int'(w.slot_number);
                    if (v > frame_shadow[idx])
                        frame_shadow[idx] = v;
                end
                r = '{dmx_level: v, universe_index: w.universe, changed: 1'b0, last: 1'b1};
                merge_results.push_back(r);
            end
            CMD_COMMIT:
            begin
                // Every universe is compared and copied; only the first REPORT_N report.
                for (int u = 0; u < UNIVERSES; u++)
                begin
                    r = '{dmx_level: 8'd0, universe_index: 2'(u), changed: 1'b0,
                          last: (u == REPORT_N - 1)};
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        idx = u * SLOTS + s;
                        if (frame_shadow[idx] != output_shadow[idx])
                            r.changed = 1'b1;
                        output_shadow[idx] = frame_shadow[idx];
                    end
                    if (u < REPORT_N)
                        merge_results.push_back(r);
                end
            end
            default:
            begin
                v = 8'd0;
                if (w.universe < UNIVERSES && w.slot_number < SLOTS)
                    v = output_shadow[int'(w.universe) * SLOTS + int'(w.slot_number)];
                r = '{dmx_level: v, universe_index: w.universe, changed: 1'b0, last: 1'b1};
                merge_results.push_back(r);
            end
        endcase
    endfunction

    // Input driver: presents queued words at the falling edge and holds them until taken.
    always @(negedge clk)
    begin : word_driver
        dmx_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (words_taken == words_offered)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() == 0)
                in_valid <= 1'b0;
            else if (pending_words[0].drain_first && merge_results.size() != 0)
                in_valid <= 1'b0;
            else
            begin
                w = pending_words.pop_front();
                cmd           <= w.cmd;
                universe      <= w.universe;
                slot_number   <= w.slot_number;
                level_a       <= w.level_a;
                level_b       <= w.level_b;
                full_value    <= w.full_value;
                own_num       <= w.own_num;
                own_den       <= w.own_den;
                has_global    <= w.has_global;
                global_num    <= w.global_num;
                global_den    <= w.global_den;
                in_valid      <= 1'b1;
                words_offered <= words_offered + 1;
                gap_left      <= draw_pause(words_offered);
            end
        end
    end

    // Receiver: after each taken result, stall for a drawn number of valid cycles.
    always @(negedge clk)
    begin : result_receiver
        int wait_now;
        wait_now = stall_left;
        if (results_taken != results_seen)
        begin
            results_seen <= results_taken;
            wait_now = draw_pause(results_taken);
        end
        else if (wait_now > 0 && out_valid)
            wait_now = wait_now - 1;
        stall_left <= wait_now;
        out_stall  <= (wait_now > 0) || (holdoff_left > 0);
    end

    // One long hold-off on the result side so the engine backs up into its input.
    always @(negedge clk)
    begin
        if (!holdoff_fired && words_taken >= HOLDOFF_AT)
        begin
            holdoff_fired <= 1'b1;
            holdoff_left  <= HOLDOFF_CYCLES;
        end
        else if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Monitor: checks result words and feeds accepted input words to the predictor.
    always @(posedge clk)
    begin : monitor
        merge_result_t want;
        dmx_word_t     seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_taken <= results_taken + 1;
                if (merge_results.size() == 0)
                    report_mismatch($sformatf("result word with nothing pending: level %0d uni %0d",
                                              dmx_level, universe_index));
                else
                begin
                    want = merge_results.pop_front();
                    if (dmx_level !== want.dmx_level)
                        report_mismatch($sformatf("dmx_level got %0d, want %0d (uni %0d)",
                                                  dmx_level, want.dmx_level,
                                                  want.universe_index));
                    if (universe_index !== want.universe_index)
                        report_mismatch($sformatf("universe_index got %0d, want %0d",
                                                  universe_index, want.universe_index));
                    if (changed !== want.changed)
                        report_mismatch($sformatf("changed got %0b, want %0b (uni %0d)",
                                                  changed, want.changed, want.universe_index));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0b, want %0b (uni %0d)",
                                                  last, want.last, want.universe_index));
                end
            end
            if (in_valid && !in_stall)
            begin
                words_taken      <= words_taken + 1;
                seen.cmd         = cmd_t'(cmd);
                seen.universe    = universe;
                seen.slot_number = slot_number;
                seen.level_a     = level_a;
                seen.level_b     = level_b;
                seen.full_value  = full_value;
                seen.own_num     = own_num;
                seen.own_den     = own_den;
                seen.has_global  = has_global;
                seen.global_num  = global_num;
                seen.global_den  = global_den;
                seen.drain_first = 1'b0;
                apply_word(seen);
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_dmx_htp_merge_engine: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        dmx_word_t w;
        int        burst;
        int        c;

        slot_pool[0] = 9'd0;
        slot_pool[1] = 9'd511;
        for (int i = 2; i < 8; i++)
            slot_pool[i] = 9'($urandom);

        // Directed words: reset contents, scaler choice, zero divisors, clamping, HTP.
        queue_word(op_word(CMD_READ, 2'd0, 9'd0));
        queue_word(contrib_word(2'd0, 9'd0, 16'hFFFF, 16'hFFFF, 16'd1, 8'hFF, 8'd1, 1'b0,
                                8'd0, 8'd1));
        queue_word(contrib_word(2'd3, 9'd511, 16'd0, 16'hFFFF, 16'hFFFF, 8'd2, 8'd3, 1'b1,
                                8'd0, 8'd1));
        queue_word(contrib_word(2'd1, 9'd5, 16'd1000, 16'd0, 16'd0, 8'd5, 8'd5, 1'b0,
                                8'd0, 8'd1));
        queue_word(contrib_word(2'd1, 9'd6, 16'd1000, 16'd2000, 16'd4000, 8'hFF, 8'd0, 1'b1,
                                8'd0, 8'd0));
        queue_word(contrib_word(2'd2, 9'd100, 16'd300, 16'd200, 16'd1000, 8'd1, 8'd1, 1'b1,
                                8'd128, 8'd255));
        queue_word(contrib_word(2'd2, 9'd101, 16'd300, 16'd200, 16'd1000, 8'd0, 8'd0, 1'b1,
                                8'hFF, 8'd0));
        queue_word(contrib_word(2'd2, 9'd102, 16'd300, 16'd200, 16'd1000, 8'd0, 8'd1, 1'b0,
                                8'd200, 8'd3));
        queue_word(contrib_word(2'd2, 9'd103, 16'd300, 16'd200, 16'd1000, 8'd1, 8'd0, 1'b0,
                                8'd7, 8'd7));
        queue_word(contrib_word(2'd0, 9'd0, 16'd10, 16'd20, 16'd100, 8'd1, 8'd1, 1'b0,
                                8'd0, 8'd1));
        queue_word(contrib_word(2'd3, 9'd511, 16'd40000, 16'd10, 16'hFFFF, 8'd4, 8'd5, 1'b1,
                                8'd9, 8'd9));
        queue_word(contrib_word(2'd3, 9'd511, 16'd100, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0,
                                8'd0, 8'd1));
        queue_word(op_word(CMD_COMMIT, 2'd0, 9'd0));
        w = op_word(CMD_READ, 2'd0, 9'd0);
        w.drain_first = 1'b1;
        queue_word(w);
        queue_word(op_word(CMD_READ, 2'd3, 9'd511));
        queue_word(op_word(CMD_READ, 2'd2, 9'd100));
        // A second commit with nothing new must report no change anywhere.
        queue_word(op_word(CMD_COMMIT, 2'd1, 9'd7));
        queue_word(op_word(CMD_CLEAR, 2'd2, 9'd9));
        queue_word(contrib_word(2'd1, 9'd300, 16'd5, 16'd5, 16'd5, 8'd1, 8'd1, 1'b1,
                                8'd1, 8'd1));
        queue_word(op_word(CMD_COMMIT, 2'd3, 9'd3));
        queue_word(op_word(CMD_READ, 2'd1, 9'd5));
        queue_word(op_word(CMD_READ, 2'd1, 9'd300));
        queue_word(contrib_word(2'd0, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 1'b1,
                                8'd0, 8'd0));

        // Random part: mostly whole frames, the rest stray words of any kind.
        c = queued_count;
        while (queued_count - c < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    case ($urandom_range(0, 3))
                        0: queue_word(($urandom_range(0, 2) == 0)
                                      ? op_word(CMD_CLEAR, 2'($urandom), 9'($urandom))
                                      : random_contrib(2'($urandom), 9'($urandom)));
                        1: queue_word(random_contrib(2'($urandom), 9'($urandom)));
                        2: queue_word(($urandom_range(0, 2) == 0)
                                      ? op_word(CMD_COMMIT, 2'($urandom), 9'($urandom))
                                      : op_word(CMD_READ, 2'($urandom), pick_slot()));
                        default: queue_word(op_word(CMD_READ, 2'($urandom), 9'($urandom)));
                    endcase
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                    queue_word(op_word(CMD_CLEAR, 2'($urandom), 9'($urandom)));
                burst = $urandom_range(1, 16);
                repeat (burst)
                    queue_word(random_contrib(2'($urandom), pick_slot()));
                queue_word(op_word(CMD_COMMIT, 2'($urandom), 9'($urandom)));
                burst = $urandom_range(0, 6);
                repeat (burst)
                    queue_word(op_word(CMD_READ, 2'($urandom), pick_slot()));
            end
        end

        // Reset is released at a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || words_taken != words_offered)
            @(posedge clk);
        while (merge_results.size() != 0)
            @(posedge clk);
        // A trailing clear may still be sweeping; give it time to finish.
        repeat (END_SETTLE) @(posedge clk);
        if (merge_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", merge_results.size()));

        if (error_count == 0)
            $display("tb_dmx_htp_merge_engine: done, clean");
        else
            $display("tb_dmx_htp_merge_engine: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dhm_pkg.sv
src/dhm_datapath.sv
src/dhm_ctrl.sv
src/dmx_htp_merge_engine.sv
dv/tb_dmx_htp_merge_engine.sv
